[rtl/core/acf_pkg.sv]
package acf_pkg;

   localparam int NUM_CHUNKS_DEF   = 64;
   localparam int LENGTH_WIDTH_DEF = 24;
   localparam int SAMPLE_W         = 16;
   localparam int QUO_W            = 31;
   localparam int ROOT_W           = 16;
   localparam int IDX_OUT_W        = 6;
   localparam int TOTAL_RESET      = 64;
   localparam int QUEUE_DEPTH      = 4;
   localparam int SQRT_STEPS       = 16;
   localparam int RSP_DATA_W       = 72;

   typedef enum logic {
      FR_ACCUM,
      FR_PAD
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DIV_A,
      BK_DIV_Q,
      BK_DIV_Z,
      BK_MUL_AA,
      BK_MUL_AB,
      BK_MUL_TN,
      BK_SUB,
      BK_DIV_M,
      BK_MUL_DN,
      BK_CMP,
      BK_SQ_R,
      BK_SQ_V,
      BK_OUT
   } back_state_type;

endpackage

[rtl/core/acf_fifo.sv]
module acf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = acf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/acf_front.sv]
module acf_front #(
   parameter int NUM_CHUNKS   = acf_pkg::NUM_CHUNKS_DEF,
   parameter int LENGTH_WIDTH = acf_pkg::LENGTH_WIDTH_DEF,
   parameter int ENTRY_W      = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [LENGTH_WIDTH-1:0] csr_wdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,
   output logic                    push,
   output logic [ENTRY_W-1:0]      push_data,
   input  logic                    full,
   output logic [LENGTH_WIDTH-1:0] len
);

   localparam int LW   = LENGTH_WIDTH;
   localparam int CCW  = $clog2(NUM_CHUNKS + 1);
   localparam int SUMW = acf_pkg::SAMPLE_W + LW;
   localparam int SQW  = 30 + LW;
   localparam int NSH  = $clog2(NUM_CHUNKS);
   localparam int KSH  = LW + NSH;
   localparam int PRW  = KSH + LW + 1;
   localparam longint unsigned RECIP =
      ((64'd1 << KSH) + longint'(NUM_CHUNKS) - 1) / longint'(NUM_CHUNKS);

   acf_pkg::front_state_type state_ff, state_in;

   logic [LW-1:0]          total_ff, total_in;
   logic [LW-1:0]          len_ff, len_in;
   logic                   ldiv_busy_ff, ldiv_busy_in;
   logic signed [SUMW-1:0] sum_ff, sum_in, sum_nx;
   logic [SQW-1:0]         sq_ff, sq_in, sq_nx;
   logic [LW-1:0]          cross_ff, cross_in, cross_nx;
   logic                   prev_ff, prev_in;
   logic [LW-1:0]          pos_ff, pos_in;
   logic [LW:0]            pos_nx, clip_nx;
   logic [CCW-1:0]         chunk_ff, chunk_in;
   logic [LW-1:0]          clip_ff, clip_in;
   logic [LW-1:0]          tot_eff;
   logic [PRW-1:0]         len_prod;
   logic signed [15:0]     smp;
   logic signed [31:0]     smp_sq;
   logic                   accept;

   assign smp        = req_tdata;
   assign smp_sq     = smp * smp;
   assign tot_eff    = (total_ff == '0) ? LW'(1) : total_ff;
   assign req_tready = !ldiv_busy_ff && (state_ff == acf_pkg::FR_ACCUM) && !full;
   assign accept     = req_tvalid && req_tready;
   assign len        = len_ff;
   // chunk length = total / chunk count by reciprocal multiply, exact over LW bits
   assign len_prod   = PRW'(tot_eff) * PRW'(RECIP);

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      len_in       = len_ff;
      ldiv_busy_in = ldiv_busy_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      cross_in     = cross_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      chunk_in     = chunk_ff;
      clip_in      = clip_ff;
      push         = 1'b0;
      push_data    = '0;
      sum_nx       = sum_ff + SUMW'(smp);
      sq_nx        = sq_ff + SQW'(smp_sq[30:0]);
      cross_nx     = cross_ff + LW'((pos_ff != '0) && (smp[15] != prev_ff));
      pos_nx       = {1'b0, pos_ff} + 1'b1;
      clip_nx      = {1'b0, clip_ff} + 1'b1;

      if (ldiv_busy_ff) begin
         ldiv_busy_in = 1'b0;
         len_in       = (len_prod[KSH +: LW] == '0) ? LW'(1) : len_prod[KSH +: LW];
      end

      case (state_ff)
         acf_pkg::FR_ACCUM: begin
            if (accept) begin
               if (chunk_ff < CCW'(NUM_CHUNKS)) begin
                  prev_in = smp[15];
                  if (pos_nx >= {1'b0, len_ff}) begin
                     push      = 1'b1;
                     push_data = {chunk_ff, sum_nx, sq_nx, cross_nx};
                     chunk_in  = chunk_ff + 1'b1;
                     sum_in    = '0;
                     sq_in     = '0;
                     cross_in  = '0;
                     prev_in   = 1'b0;
                     pos_in    = '0;
                  end else begin
                     sum_in   = sum_nx;
                     sq_in    = sq_nx;
                     cross_in = cross_nx;
                     pos_in   = pos_nx[LW-1:0];
                  end
               end
               if (clip_nx >= {1'b0, tot_eff}) begin
                  sum_in   = '0;
                  sq_in    = '0;
                  cross_in = '0;
                  prev_in  = 1'b0;
                  pos_in   = '0;
                  clip_in  = '0;
                  if (chunk_in < CCW'(NUM_CHUNKS)) begin
                     state_in = acf_pkg::FR_PAD;
                  end else begin
                     chunk_in = '0;
                  end
               end else begin
                  clip_in = clip_nx[LW-1:0];
               end
            end
         end
         acf_pkg::FR_PAD: begin
            // short clip: fill the rest of the set with empty chunks
            if (!full) begin
               push      = 1'b1;
               push_data = {chunk_ff, {(ENTRY_W - CCW){1'b0}}};
               if (chunk_ff == CCW'(NUM_CHUNKS - 1)) begin
                  chunk_in = '0;
                  state_in = acf_pkg::FR_ACCUM;
               end else begin
                  chunk_in = chunk_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = acf_pkg::FR_ACCUM;
         end
      endcase

      if (csr_we) begin
         total_in     = csr_wdata;
         ldiv_busy_in = 1'b1;
         state_in     = acf_pkg::FR_ACCUM;
         sum_in       = '0;
         sq_in        = '0;
         cross_in     = '0;
         prev_in      = 1'b0;
         pos_in       = '0;
         chunk_in     = '0;
         clip_in      = '0;
         push         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acf_pkg::FR_ACCUM;
         total_ff     <= LW'(acf_pkg::TOTAL_RESET);
         len_ff       <= LW'(1);
         ldiv_busy_ff <= 1'b1;
         sum_ff       <= '0;
         sq_ff        <= '0;
         cross_ff     <= '0;
         prev_ff      <= 1'b0;
         pos_ff       <= '0;
         chunk_ff     <= '0;
         clip_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         len_ff       <= len_in;
         ldiv_busy_ff <= ldiv_busy_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         cross_ff     <= cross_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         chunk_ff     <= chunk_in;
         clip_ff      <= clip_in;
      end
   end

endmodule

[rtl/core/acf_div.sv]
module acf_div #(
   parameter int LENGTH_WIDTH = acf_pkg::LENGTH_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [30+LENGTH_WIDTH-1:0]    num,
   input  logic [LENGTH_WIDTH-1:0]       den,
   output logic                          done,
   output logic [acf_pkg::QUO_W-1:0]     quo,
   output logic [LENGTH_WIDTH-1:0]       rem
);

   localparam int LW  = LENGTH_WIDTH;
   localparam int SQW = 30 + LW;
   localparam int QW  = acf_pkg::QUO_W;
   localparam int NW  = $clog2(QW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW:0]   trial;

   assign trial = {rem_ff, quo_ff[QW-1]};
   assign done  = done_ff;
   assign quo   = quo_ff;
   assign rem   = rem_ff;

   // quotient always fits QW bits, so the top bits of num start as partial remainder
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num[QW-1:0];
         rem_in  = {1'b0, num[SQW-1:QW]};
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in = LW'(trial - {1'b0, den});
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[LW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

[rtl/core/acf_back.sv]
module acf_back #(
   parameter int NUM_CHUNKS   = acf_pkg::NUM_CHUNKS_DEF,
   parameter int LENGTH_WIDTH = acf_pkg::LENGTH_WIDTH_DEF,
   parameter int ENTRY_W      = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [LENGTH_WIDTH-1:0]        len,
   input  logic                           empty,
   input  logic [ENTRY_W-1:0]             pop_data,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [acf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int LW   = LENGTH_WIDTH;
   localparam int CCW  = $clog2(NUM_CHUNKS + 1);
   localparam int XW   = (CCW > acf_pkg::IDX_OUT_W) ? CCW : acf_pkg::IDX_OUT_W;
   localparam int SUMW = acf_pkg::SAMPLE_W + LW;
   localparam int SQW  = 30 + LW;
   localparam int QW   = acf_pkg::QUO_W;
   localparam int UW   = 16 + LW;
   localparam int SUBW = 33 + LW;
   localparam int RW   = acf_pkg::ROOT_W;
   localparam int SCW  = $clog2(acf_pkg::SQRT_STEPS);

   acf_pkg::back_state_type state_ff, state_in;

   logic [CCW-1:0]  idx_ff, idx_in;
   logic            sneg_ff, sneg_in;
   logic [SQW-1:0]  sq_ff, sq_in;
   logic [LW-1:0]   cross_ff, cross_in;
   logic [15:0]     a_ff, a_in;
   logic [LW-1:0]   b_ff, b_in;
   logic [QW-1:0]   qn_ff, qn_in;
   logic [15:0]     zcr_ff, zcr_in;
   logic [15:0]     mean_ff, mean_in;
   logic [31:0]     t_ff, t_in;
   logic [UW-1:0]   u_ff, u_in;
   logic [SUBW-1:0] sub_ff, sub_in;
   logic [QW-1:0]   c_ff, c_in;
   logic [LW-1:0]   d_ff, d_in;
   logic [2*LW-1:0] dn_ff, dn_in, bb;
   logic [QW-1:0]   var_ff, var_in;
   logic [RW-1:0]   rms_ff, rms_in;
   logic [31:0]     sv_ff, sv_in, root_ff, root_in, bit_ff, bit_in;
   logic [31:0]     root_sum, sv_step, root_step;
   logic [SCW-1:0]  scnt_ff, scnt_in;
   logic            ovalid_ff, ovalid_in;
   logic [acf_pkg::RSP_DATA_W-1:0] odata_ff, odata_in;
   logic            olast_ff, olast_in;

   logic            div_start, div_done;
   logic [SQW-1:0]  div_num;
   logic [QW-1:0]   div_quo;
   logic [LW-1:0]   div_rem;

   logic signed [SUMW-1:0] e_sum;
   logic [SUMW-1:0]        e_abs;
   logic [SQW-1:0]         e_sq;
   logic [LW-1:0]          e_cross;
   logic [CCW-1:0]         e_idx;
   logic [SUBW-1:0]        sq_wide;
   logic [XW-1:0]          idx_wide;

   assign e_cross  = pop_data[LW-1:0];
   assign e_sq     = pop_data[LW +: SQW];
   assign e_sum    = pop_data[LW + SQW +: SUMW];
   assign e_idx    = pop_data[LW + SQW + SUMW +: CCW];
   assign e_abs    = e_sum[SUMW-1] ? (SUMW'(0) - e_sum) : e_sum;
   assign sq_wide  = SUBW'(sq_ff);
   assign bb       = (2 * LW)'(b_ff) * (2 * LW)'(b_ff);
   assign idx_wide = XW'(idx_ff);

   assign root_sum  = root_ff + bit_ff;
   assign sv_step   = (sv_ff >= root_sum) ? sv_ff - root_sum : sv_ff;
   assign root_step = (sv_ff >= root_sum) ? (root_ff >> 1) + bit_ff : root_ff >> 1;

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;

   acf_div #(
      .LENGTH_WIDTH(LW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (len),
      .done (div_done),
      .quo  (div_quo),
      .rem  (div_rem)
   );

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      sneg_in   = sneg_ff;
      sq_in     = sq_ff;
      cross_in  = cross_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      qn_in     = qn_ff;
      zcr_in    = zcr_ff;
      mean_in   = mean_ff;
      t_in      = t_ff;
      u_in      = u_ff;
      sub_in    = sub_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      dn_in     = dn_ff;
      var_in    = var_ff;
      rms_in    = rms_ff;
      sv_in     = sv_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      scnt_in   = scnt_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      olast_in  = olast_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      div_num   = '0;

      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end

      case (state_ff)
         acf_pkg::BK_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               idx_in    = e_idx;
               sneg_in   = e_sum[SUMW-1];
               sq_in     = e_sq;
               cross_in  = e_cross;
               div_start = 1'b1;
               div_num   = SQW'(e_abs);
               state_in  = acf_pkg::BK_DIV_A;
            end
         end
         acf_pkg::BK_DIV_A: begin
            if (div_done) begin
               a_in      = div_quo[15:0];
               b_in      = div_rem;
               mean_in   = sneg_ff ? (16'd0 - div_quo[15:0]) : div_quo[15:0];
               div_start = 1'b1;
               div_num   = sq_ff;
               state_in  = acf_pkg::BK_DIV_Q;
            end
         end
         acf_pkg::BK_DIV_Q: begin
            if (div_done) begin
               qn_in     = div_quo;
               div_start = 1'b1;
               div_num   = SQW'({cross_ff, 16'd0});
               state_in  = acf_pkg::BK_DIV_Z;
            end
         end
         acf_pkg::BK_DIV_Z: begin
            if (div_done) begin
               zcr_in   = div_quo[15:0];
               state_in = acf_pkg::BK_MUL_AA;
            end
         end
         acf_pkg::BK_MUL_AA: begin
            t_in     = 32'(a_ff) * 32'(a_ff);
            state_in = acf_pkg::BK_MUL_AB;
         end
         acf_pkg::BK_MUL_AB: begin
            u_in     = UW'(a_ff) * UW'(b_ff);
            state_in = acf_pkg::BK_MUL_TN;
         end
         acf_pkg::BK_MUL_TN: begin
            // part of sumsq that sum^2/n accounts for: a*a*n + 2*a*b
            sub_in   = SUBW'(t_ff) * SUBW'(len) + SUBW'({u_ff, 1'b0});
            state_in = acf_pkg::BK_SUB;
         end
         acf_pkg::BK_SUB: begin
            if (sq_wide < sub_ff) begin
               var_in   = '0;
               sv_in    = 32'(qn_ff);
               root_in  = '0;
               bit_in   = 32'h4000_0000;
               scnt_in  = '0;
               state_in = acf_pkg::BK_SQ_R;
            end else begin
               div_start = 1'b1;
               div_num   = SQW'(sq_wide - sub_ff);
               state_in  = acf_pkg::BK_DIV_M;
            end
         end
         acf_pkg::BK_DIV_M: begin
            if (div_done) begin
               c_in     = div_quo;
               d_in     = div_rem;
               state_in = acf_pkg::BK_MUL_DN;
            end
         end
         acf_pkg::BK_MUL_DN: begin
            dn_in    = (2 * LW)'(d_ff) * (2 * LW)'(len);
            state_in = acf_pkg::BK_CMP;
         end
         acf_pkg::BK_CMP: begin
            if (dn_ff >= bb) begin
               var_in = c_ff;
            end else begin
               var_in = (c_ff == '0) ? '0 : c_ff - 1'b1;
            end
            sv_in    = 32'(qn_ff);
            root_in  = '0;
            bit_in   = 32'h4000_0000;
            scnt_in  = '0;
            state_in = acf_pkg::BK_SQ_R;
         end
         acf_pkg::BK_SQ_R: begin
            sv_in   = sv_step;
            root_in = root_step;
            bit_in  = bit_ff >> 2;
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == SCW'(acf_pkg::SQRT_STEPS - 1)) begin
               rms_in   = root_step[RW-1:0];
               sv_in    = 32'(var_ff);
               root_in  = '0;
               bit_in   = 32'h4000_0000;
               scnt_in  = '0;
               state_in = acf_pkg::BK_SQ_V;
            end
         end
         acf_pkg::BK_SQ_V: begin
            sv_in   = sv_step;
            root_in = root_step;
            bit_in  = bit_ff >> 2;
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == SCW'(acf_pkg::SQRT_STEPS - 1)) begin
               state_in = acf_pkg::BK_OUT;
            end
         end
         acf_pkg::BK_OUT: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               odata_in  = {2'b00, root_ff[RW-1:0], mean_ff, zcr_ff, rms_ff,
                            idx_wide[acf_pkg::IDX_OUT_W-1:0]};
               olast_in  = (idx_ff == CCW'(NUM_CHUNKS - 1));
               state_in  = acf_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = acf_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= acf_pkg::BK_IDLE;
         ovalid_ff <= 1'b0;
         scnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         scnt_ff   <= scnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      sneg_ff  <= sneg_in;
      sq_ff    <= sq_in;
      cross_ff <= cross_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      qn_ff    <= qn_in;
      zcr_ff   <= zcr_in;
      mean_ff  <= mean_in;
      t_ff     <= t_in;
      u_ff     <= u_in;
      sub_ff   <= sub_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      dn_ff    <= dn_in;
      var_ff   <= var_in;
      rms_ff   <= rms_in;
      sv_ff    <= sv_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
   end

endmodule

[rtl/core/audio_chunk_features.sv]
// channel   dir  handshake              word
// req       in   req_tvalid/req_tready  req_tdata: sample
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata: chunk_index, rms, rate, mean, std; tlast
// csr       in   csr_we                 csr_wdata: total_samples
//
// the front takes one sample per cycle and posts each finished chunk to a 4-entry queue
// the back pops a chunk only when idle, then runs four serial 31-step divides by the
// chunk length (three if the variance term is negative), multiplies and two 16-step roots
// after reset or a csr write req stalls while the chunk length is recomputed
// req stalls on a full queue and while a short clip pads, one chunk per cycle unless full
module audio_chunk_features #(
   parameter int NUM_CHUNKS   = acf_pkg::NUM_CHUNKS_DEF,
   parameter int LENGTH_WIDTH = acf_pkg::LENGTH_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [LENGTH_WIDTH-1:0]        csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,  // sample
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // chunk_index[5:0], rms_level, crossing_rate, mean_level, std_dev, zero pad
   output logic [acf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int LW      = LENGTH_WIDTH;
   localparam int CCW     = $clog2(NUM_CHUNKS + 1);
   localparam int ENTRY_W = CCW + (acf_pkg::SAMPLE_W + LW) + (30 + LW) + LW;

   logic               push, pop, full, empty;
   logic [ENTRY_W-1:0] push_data, pop_data;
   logic [LW-1:0]      len;

   acf_front #(
      .NUM_CHUNKS  (NUM_CHUNKS),
      .LENGTH_WIDTH(LW),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .len       (len)
   );

   acf_fifo #(
      .WIDTH(ENTRY_W),
      .DEPTH(acf_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .full     (full),
      .empty    (empty)
   );

   acf_back #(
      .NUM_CHUNKS  (NUM_CHUNKS),
      .LENGTH_WIDTH(LW),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .len       (len),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
